/* hdl/ubd_pkg.sv */
package ubd_pkg;

   // field widths
   localparam int unsigned CLK_W    = 27;
   localparam int unsigned BAUD_W   = 23;
   localparam int unsigned PORT_W   = 2;
   localparam int unsigned FRAC_W   = 4;
   localparam int unsigned CSR_IDX_W = 1;

   // quotient of clock / baud carries mantissa and fraction bits together
   localparam int unsigned QUOT_W   = CLK_W;
   localparam int unsigned MRAW_W   = QUOT_W - FRAC_W;

   // reset values of the bus clocks
   localparam logic [CLK_W-1:0] FAST_CLK_RESET = 27'd72000000;
   localparam logic [CLK_W-1:0] SLOW_CLK_RESET = 27'd36000000;

   // port that runs from the fast bus clock
   localparam logic [PORT_W-1:0] FAST_PORT = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_CLK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_CLK = 1'b1;

   // saturated fraction and the exact half
   localparam logic [FRAC_W-1:0] FRAC_MAX = 4'hF;
   localparam logic [FRAC_W-1:0] FRAC_HALF = 4'h8;

   // payload handed from one divider cell to the next
   typedef struct packed {
      logic              baud_zero;
      logic [BAUD_W-1:0] baud;
      logic [BAUD_W-1:0] rem;
      logic [QUOT_W-1:0] num;
   } ubd_stage_type;

endpackage

/* hdl/ubd_div_cell.sv */
module ubd_div_cell
   import ubd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  ubd_stage_type stage_in,
   output logic          valid_out,
   output ubd_stage_type stage_out
);

   logic          valid_ff;
   ubd_stage_type stage_ff;
   ubd_stage_type stage_in_c;

   logic [BAUD_W:0] trial;
   logic [BAUD_W:0] diff;
   logic            take;

   // one restoring step: bring down the next dividend bit, try to subtract
   always_comb begin
      trial      = {stage_in.rem, stage_in.num[QUOT_W-1]};
      diff       = trial - {1'b0, stage_in.baud};
      take       = (trial >= {1'b0, stage_in.baud});
      stage_in_c = stage_in;
      stage_in_c.rem = take ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
      stage_in_c.num = {stage_in.num[QUOT_W-2:0], take};
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      stage_ff <= stage_in_c;
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

/* hdl/ubd_round.sv */
module ubd_round
   import ubd_pkg::*;
#(
   parameter int unsigned MANTISSA_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_in,
   input  ubd_stage_type            stage_in,
   output logic                     rsp_valid,
   output logic [MANTISSA_BITS-1:0] rsp_divisor_mantissa,
   output logic [FRAC_W-1:0]        rsp_divisor_fraction,
   output logic                     rsp_out_of_range
);

   localparam logic [MRAW_W:0] MANT_MAX = (MRAW_W+1)'((1 << MANTISSA_BITS) - 1);

   logic                     valid_ff;
   logic [MANTISSA_BITS-1:0] mant_ff;
   logic [FRAC_W-1:0]        frac_ff;
   logic                     err_ff;

   logic [FRAC_W-1:0]        frac_raw;
   logic                     round_up;
   logic [FRAC_W:0]          frac_sum;
   logic [MRAW_W:0]          mant_sum;
   logic                     over;
   logic [MANTISSA_BITS-1:0] mant_in;
   logic [FRAC_W-1:0]        frac_in;
   logic                     err_in;

   // round half up, exact half stays down; carry a full unit into the mantissa
   always_comb begin
      frac_raw = stage_in.num[FRAC_W-1:0];
      round_up = frac_raw[FRAC_W-1] &&
                 !((frac_raw == FRAC_HALF) && (stage_in.rem == '0));
      frac_sum = {1'b0, frac_raw} + {{FRAC_W{1'b0}}, round_up};
      mant_sum = {1'b0, stage_in.num[QUOT_W-1:FRAC_W]} + {{MRAW_W{1'b0}}, frac_sum[FRAC_W]};
      over     = stage_in.baud_zero || (mant_sum > MANT_MAX);
      err_in   = over;
      mant_in  = over ? MANT_MAX[MANTISSA_BITS-1:0] : mant_sum[MANTISSA_BITS-1:0];
      frac_in  = over ? FRAC_MAX : frac_sum[FRAC_W-1:0];
   end

   // strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
      frac_ff <= frac_in;
      err_ff  <= err_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_divisor_mantissa = mant_ff;
   assign rsp_divisor_fraction = frac_ff;
   assign rsp_out_of_range     = err_ff;

endmodule

/* hdl/uart_baud_divisor_calc.sv */
// Computes the 16x-oversampling UART divisor for a port and baud rate. The
// quotient bus_clock / baud is formed by a row of 27 divider cells, one
// quotient bit per cell, followed by one rounding and saturation stage. A new
// request may be started in every cycle; busy is always low. Results cannot be
// held off by the receiver and must be captured in the strobe cycle. The user
// writes the bus clock registers through the csr port only while no request
// is in flight; the block itself does not enforce this.
module uart_baud_divisor_calc
   import ubd_pkg::*;
#(
   parameter int unsigned MANTISSA_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [PORT_W-1:0]        req_port_number,
   input  logic [BAUD_W-1:0]        req_baud_rate,
   output logic                     rsp_valid,
   output logic [MANTISSA_BITS-1:0] rsp_divisor_mantissa,
   output logic [FRAC_W-1:0]        rsp_divisor_fraction,
   output logic                     rsp_out_of_range,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CLK_W-1:0]         csr_wdata
);

   localparam int unsigned LATENCY = QUOT_W + 1;

   logic [CLK_W-1:0] fast_clk_ff;
   logic [CLK_W-1:0] slow_clk_ff;

   logic          valid_head;
   ubd_stage_type stage_head;

   logic          valid_bus [0:QUOT_W];
   ubd_stage_type stage_bus [0:QUOT_W];

   // bus clock registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_clk_ff <= FAST_CLK_RESET;
         slow_clk_ff <= SLOW_CLK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FAST_CLK: fast_clk_ff <= csr_wdata;
            CSR_SLOW_CLK: slow_clk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request enters the first cell
   assign busy = 1'b0;

   always_comb begin
      valid_head           = start && !busy;
      stage_head.baud_zero = (req_baud_rate == '0);
      stage_head.baud      = req_baud_rate;
      stage_head.rem       = '0;
      stage_head.num       = (req_port_number == FAST_PORT) ? fast_clk_ff : slow_clk_ff;
   end

   assign valid_bus[0] = valid_head;
   assign stage_bus[0] = stage_head;

   // divider cells
   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      ubd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_bus[i]),
         .stage_in  (stage_bus[i]),
         .valid_out (valid_bus[i+1]),
         .stage_out (stage_bus[i+1])
      );
   end

   // rounding, carry and saturation
   ubd_round #(
      .MANTISSA_BITS (MANTISSA_BITS)
   ) u_round (
      .clock                (clock),
      .reset                (reset),
      .valid_in             (valid_bus[QUOT_W]),
      .stage_in             (stage_bus[QUOT_W]),
      .rsp_valid            (rsp_valid),
      .rsp_divisor_mantissa (rsp_divisor_mantissa),
      .rsp_divisor_fraction (rsp_divisor_fraction),
      .rsp_out_of_range     (rsp_out_of_range)
   );

   // every request gives a strobe after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request without result");

   // no strobe without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without request");

   // saturated results carry the full fraction
   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_divisor_fraction == FRAC_MAX))
      else $error("out of range result not saturated");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import ubd_pkg::*;

   localparam int unsigned MANT_W      = 12;
   localparam int unsigned LATENCY     = 28;
   localparam int unsigned OVERSAMPLE  = 16;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam logic [BAUD_W-1:0] BAUD_MAX = '1;
   localparam logic [CLK_W-1:0]  CLK_MAX  = '1;

   typedef struct packed {
      logic [MANT_W-1:0] mantissa;
      logic [FRAC_W-1:0] fraction;
      logic              out_of_range;
   } divisor_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [PORT_W-1:0]   req_port_number;
   logic [BAUD_W-1:0]   req_baud_rate;
   logic                rsp_valid;
   logic [MANT_W-1:0]   rsp_divisor_mantissa;
   logic [FRAC_W-1:0]   rsp_divisor_fraction;
   logic                rsp_out_of_range;
   logic                csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CLK_W-1:0]    csr_wdata;

   // bench copy of the bus clock registers
   logic [CLK_W-1:0]    fast_clk_hz;
   logic [CLK_W-1:0]    slow_clk_hz;

   divisor_type         divisor_q[$];
   divisor_type         oldest_divisor;
   int unsigned         n_requests;
   int unsigned         n_results;
   int unsigned         n_saturated;
   int unsigned         n_settings;
   int unsigned         n_mismatch;
   int unsigned         cycle_count;

   uart_baud_divisor_calc #(
      .MANTISSA_BITS(MANT_W)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_port_number      (req_port_number),
      .req_baud_rate        (req_baud_rate),
      .rsp_valid            (rsp_valid),
      .rsp_divisor_mantissa (rsp_divisor_mantissa),
      .rsp_divisor_fraction (rsp_divisor_fraction),
      .rsp_out_of_range     (rsp_out_of_range),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // divisor from the selected bus clock, rounded to sixteenths, saturated on overflow or zero baud
   function automatic divisor_type predict_divisor(input logic [PORT_W-1:0] port,
                                                   input logic [BAUD_W-1:0] baud);
      longint unsigned clk_hz;
      longint unsigned den;
      longint unsigned rem;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned mant_max;
      divisor_type     res;
      mant_max = (64'd1 << MANT_W) - 1;
      clk_hz = (port == FAST_PORT) ? 64'(fast_clk_hz) : 64'(slow_clk_hz);
      res.out_of_range = 1'b0;
      if (baud == '0) begin
         res.out_of_range = 1'b1;
         whole = mant_max;
         frac = 64'(FRAC_MAX);
      end else begin
         den = 64'(baud) * OVERSAMPLE;
         whole = clk_hz / den;
         rem = clk_hz % den;
         frac = (rem * OVERSAMPLE) / den;
         if (rem * 2 > den) frac++;
         // rounding up to a full unit moves into the mantissa
         if (frac >= OVERSAMPLE) begin
            frac = 0;
            whole++;
         end
         if (whole > mant_max) begin
            res.out_of_range = 1'b1;
            whole = mant_max;
            frac = 64'(FRAC_MAX);
         end
      end
      res.mantissa = whole[MANT_W-1:0];
      res.fraction = frac[FRAC_W-1:0];
      return res;
   endfunction

   // baud mix: mostly in the representable band, plus zero, full-width, near-maximum, tiny and saturation-edge rates
   function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLK_W-1:0] clk_hz);
      int unsigned kind;
      int unsigned lo;
      int unsigned hi;
      kind = $urandom_range(99);
      lo = clk_hz / (OVERSAMPLE << MANT_W) + 1;
      hi = clk_hz / OVERSAMPLE;
      if (hi > BAUD_MAX) hi = BAUD_MAX;
      if (kind < 5) return '0;
      if (kind < 12) return BAUD_W'($urandom);
      if (kind < 17) return BAUD_MAX - BAUD_W'($urandom_range(15));
      if (kind < 27 || lo > hi) return BAUD_W'($urandom_range(64, 1));
      // edge of mantissa saturation
      if (kind < 33) return BAUD_W'(lo - $urandom_range(1));
      return BAUD_W'($urandom_range(hi, lo));
   endfunction

   function automatic logic [CLK_W-1:0] pick_clock();
      case ($urandom_range(3))
         0: return CLK_W'($urandom);
         1: return CLK_W'($urandom_range(72000000, 1000000));
         2: return CLK_W'($urandom_range(200000, 1));
         default: return CLK_MAX - CLK_W'($urandom_range(255));
      endcase
   endfunction

   // one request, held until taken, then its divisor is queued
   task automatic send_request(input logic [PORT_W-1:0] port, input logic [BAUD_W-1:0] baud);
      divisor_type predicted;
      req_port_number <= port;
      req_baud_rate <= baud;
      if (!start) start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = predict_divisor(port, baud);
      divisor_q.push_back(predicted);
      n_requests++;
      if (predicted.out_of_range) n_saturated++;
   endtask

   task automatic pause_requests(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until every queued divisor came back and the pipeline is empty
   task automatic wait_for_results;
      pause_requests(1);
      while (divisor_q.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_bus_clock(input logic [CSR_IDX_W-1:0] index,
                                  input logic [CLK_W-1:0] hz);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= hz;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_FAST_CLK) fast_clk_hz = hz;
      else slow_clk_hz = hz;
      @(posedge clock);
   endtask

   task automatic set_bus_clocks(input logic [CLK_W-1:0] fast_hz, input logic [CLK_W-1:0] slow_hz);
      wait_for_results();
      write_bus_clock(CSR_FAST_CLK, fast_hz);
      write_bus_clock(CSR_SLOW_CLK, slow_hz);
      n_settings++;
   endtask

   // reset clocks: common rates, zero rate, widest rate, rate above clock/16
   task automatic test_reset_clocks;
      send_request(2'd1, 23'd115200);
      send_request(2'd2, 23'd9600);
      send_request(2'd3, 23'd4500000);
      send_request(2'd0, 23'd0);
      send_request(2'd1, BAUD_MAX);
      send_request(2'd2, 23'd1);
      send_request(2'd1, 23'd2250000);
   endtask

   // rounding carry, carry into saturation, clock extremes including zero
   task automatic test_rounding_corners;
      set_bus_clocks(27'd31999, 27'd65535);
      send_request(2'd1, 23'd1000);
      send_request(2'd2, 23'd1);
      send_request(2'd3, 23'd2);
      set_bus_clocks(CLK_MAX, 27'd65527);
      send_request(2'd1, 23'd1);
      send_request(2'd1, BAUD_MAX);
      send_request(2'd0, 23'd1);
      send_request(2'd3, 23'd0);
      set_bus_clocks(27'd65536, '0);
      send_request(2'd1, 23'd1);
      send_request(2'd2, 23'd5);
      send_request(2'd2, BAUD_MAX);
   endtask

   // random requests over several clock settings and sender idle rates
   task automatic test_random_traffic;
      int unsigned       idle_pct;
      logic [PORT_W-1:0] port;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 71;
            default: idle_pct = 36;
         endcase
         case (phase)
            1: set_bus_clocks(CLK_MAX, 27'd1);
            4: set_bus_clocks(27'd1, CLK_MAX);
            5: set_bus_clocks(FAST_CLK_RESET, SLOW_CLK_RESET);
            default: set_bus_clocks(pick_clock(), pick_clock());
         endcase
         for (int k = 0; k < 170; k++) begin
            port = PORT_W'($urandom_range(3));
            send_request(port, pick_baud((port == FAST_PORT) ? fast_clk_hz : slow_clk_hz));
            // back-to-back bursts inside the idle phases
            if ((k % 40) >= 10 && $urandom_range(99) < idle_pct)
               pause_requests($urandom_range(6, 1));
         end
      end
   endtask

   // compare each strobed result with the oldest queued divisor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_results++;
         if (divisor_q.size() == 0) begin
            $error("unexpected result: mantissa %0d fraction %0d out_of_range %0b",
                   rsp_divisor_mantissa, rsp_divisor_fraction, rsp_out_of_range);
            n_mismatch++;
         end else begin
            oldest_divisor = divisor_q.pop_front();
            if (rsp_divisor_mantissa !== oldest_divisor.mantissa) begin
               $error("divisor_mantissa: expected %0d, got %0d",
                      oldest_divisor.mantissa, rsp_divisor_mantissa);
               n_mismatch++;
            end
            if (rsp_divisor_fraction !== oldest_divisor.fraction) begin
               $error("divisor_fraction: expected %0d, got %0d",
                      oldest_divisor.fraction, rsp_divisor_fraction);
               n_mismatch++;
            end
            if (rsp_out_of_range !== oldest_divisor.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b",
                      oldest_divisor.out_of_range, rsp_out_of_range);
               n_mismatch++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, divisor_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // reset, then the tests in turn
   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_port_number <= '0;
      req_baud_rate <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_FAST_CLK;
      csr_wdata <= '0;
      fast_clk_hz = FAST_CLK_RESET;
      slow_clk_hz = SLOW_CLK_RESET;
      n_requests = 0;
      n_results = 0;
      n_saturated = 0;
      n_settings = 1;
      n_mismatch = 0;
      cycle_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_clocks();
      test_rounding_corners();
      test_random_traffic();
      wait_for_results();
      $display("covered %0d requests on all ports over %0d bus clock settings",
               n_requests, n_settings);
      $display("checked %0d results, %0d of them saturated", n_results, n_saturated);
      if (n_mismatch == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
hdl/ubd_pkg.sv
hdl/ubd_div_cell.sv
hdl/ubd_round.sv
hdl/uart_baud_divisor_calc.sv
bench/tb_top.sv
